[rtl/core/hsl_color_matrix_generator_unit_defines.svh]
// assertion macros for the hsl color matrix generator
`ifndef HSL_COLOR_MATRIX_GENERATOR_UNIT_DEFINES_SVH
`define HSL_COLOR_MATRIX_GENERATOR_UNIT_DEFINES_SVH
// assert that a property holds at every clock edge, skipped in reset
`define HCM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// assert an implication, skipped in reset
`define HCM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`endif

[rtl/core/hcm_pkg.sv]
// shared constants, tables and types for the hsl color matrix generator
package hcm_pkg;
  localparam int unsigned NumSteps = 16;
  localparam int unsigned NumElem = 9;
  localparam logic signed [16:0] HueMax = 17'sd23040;
  localparam logic signed [16:0] QuarterTurn = 17'sd5760;
  localparam logic [15:0] SatMax = 16'd25600;
  localparam logic signed [15:0] OneQ14 = 16'sd16384;
  localparam logic signed [31:0] CordicX0 = 32'sd652032874;
  localparam logic signed [21:0] CoefMax = 22'sd2097151;
  localparam logic signed [21:0] CoefMin = -22'sd2097152;

  typedef logic signed [31:0] cordic_t;
  typedef logic signed [23:0] angle_t;
  typedef logic signed [16:0] trig_t;
  typedef logic signed [21:0] coef_t;

  function automatic angle_t atan_lut(input logic [3:0] idx);
    angle_t a;
    case (idx)
      4'd0:  a = 24'sd2949120;
      4'd1:  a = 24'sd1740967;
      4'd2:  a = 24'sd919879;
      4'd3:  a = 24'sd466945;
      4'd4:  a = 24'sd234379;
      4'd5:  a = 24'sd117304;
      4'd6:  a = 24'sd58666;
      4'd7:  a = 24'sd29335;
      4'd8:  a = 24'sd14668;
      4'd9:  a = 24'sd7334;
      4'd10: a = 24'sd3667;
      4'd11: a = 24'sd1833;
      4'd12: a = 24'sd917;
      4'd13: a = 24'sd458;
      4'd14: a = 24'sd229;
      default: a = 24'sd115;
    endcase
    return a;
  endfunction

  // element constants: cos weight (as, sa), sin weight (as, sa)
  function automatic logic signed [16:0] elem_k(input logic [3:0] e, input logic [1:0] f);
    logic signed [16:0] k;
    logic signed [16:0] ca, cb, sa, sb;
    ca = 17'sd0; cb = 17'sd0; sa = 17'sd0; sb = 17'sd0;
    case (e)
      4'd0: begin ca = -17'sd1621;  cb = 17'sd43691;  sa = 17'sd19956;  sb = 17'sd0; end
      4'd1: begin ca = -17'sd1621;  cb = -17'sd21845; sa = 17'sd19956;  sb = 17'sd37838; end
      4'd2: begin ca = -17'sd1621;  cb = -17'sd21845; sa = 17'sd19956;  sb = -17'sd37838; end
      4'd3: begin ca = 17'sd18093;  cb = -17'sd21845; sa = -17'sd8574;  sb = -17'sd37838; end
      4'd4: begin ca = 17'sd18093;  cb = 17'sd43691;  sa = -17'sd8574;  sb = 17'sd0; end
      4'd5: begin ca = 17'sd18093;  cb = -17'sd21845; sa = -17'sd8574;  sb = 17'sd37838; end
      4'd6: begin ca = -17'sd16472; cb = -17'sd21845; sa = -17'sd11382; sb = 17'sd37838; end
      4'd7: begin ca = -17'sd16472; cb = -17'sd21845; sa = -17'sd11382; sb = -17'sd37838; end
      default: begin ca = -17'sd16472; cb = 17'sd43691; sa = -17'sd11382; sb = 17'sd0; end
    endcase
    case (f)
      2'd0: k = ca;
      2'd1: k = cb;
      2'd2: k = sa;
      default: k = sb;
    endcase
    return k;
  endfunction

  function automatic logic elem_diag(input logic [3:0] e);
    return (e == 4'd0) || (e == 4'd4) || (e == 4'd8);
  endfunction
endpackage

[rtl/core/hcm_cordic.sv]
// pipelined 16-step cordic producing q1.14 cosine and sine of the hue
module hcm_cordic (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [14:0]           hue_i,
  output logic                  valid_o,
  output hcm_pkg::trig_t        cos_o,
  output hcm_pkg::trig_t        sin_o
);
  import hcm_pkg::*;

  // stage 0: quadrant split
  logic        v0_q;
  logic [1:0]  quad0_q;
  angle_t      z0_q;
  logic [1:0]  quad0_d;
  logic [12:0] rem0_d;

  always_comb begin
    quad0_d = 2'd0;
    rem0_d = hue_i[12:0];
    if ({2'b00, hue_i} >= 17'd17280) begin
      quad0_d = 2'd3; rem0_d = 13'(hue_i - 15'd17280);
    end else if ({2'b00, hue_i} >= 17'd11520) begin
      quad0_d = 2'd2; rem0_d = 13'(hue_i - 15'd11520);
    end else if ({2'b00, hue_i} >= 17'(QuarterTurn)) begin
      quad0_d = 2'd1; rem0_d = 13'(hue_i - 15'd5760);
    end
    // full turn reads as zero degrees
    if ({2'b00, hue_i} == 17'(HueMax)) begin
      quad0_d = 2'd0; rem0_d = 13'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    quad0_q <= quad0_d;
    z0_q <= angle_t'({1'b0, rem0_d, 10'd0});
  end

  // iteration stages, two steps per register stage
  localparam int unsigned NumStg = NumSteps / 2;
  logic    v_q [NumStg+1];
  logic [1:0] qd_q [NumStg+1];
  cordic_t x_q [NumStg+1];
  cordic_t y_q [NumStg+1];
  angle_t  z_q [NumStg+1];

  always_comb begin
    v_q[0] = v0_q;
    qd_q[0] = quad0_q;
    x_q[0] = CordicX0;
    y_q[0] = '0;
    z_q[0] = z0_q;
  end

  for (genvar g = 0; g < NumStg; g++) begin : g_stage
    cordic_t xa, ya, xb, yb;
    angle_t za, zb;
    always_comb begin
      if (z_q[g] >= 0) begin
        xa = x_q[g] - (y_q[g] >>> (2 * g));
        ya = y_q[g] + (x_q[g] >>> (2 * g));
        za = z_q[g] - atan_lut(4'(2 * g));
      end else begin
        xa = x_q[g] + (y_q[g] >>> (2 * g));
        ya = y_q[g] - (x_q[g] >>> (2 * g));
        za = z_q[g] + atan_lut(4'(2 * g));
      end
      if (za >= 0) begin
        xb = xa - (ya >>> (2 * g + 1));
        yb = ya + (xa >>> (2 * g + 1));
        zb = za - atan_lut(4'(2 * g + 1));
      end else begin
        xb = xa + (ya >>> (2 * g + 1));
        yb = ya - (xa >>> (2 * g + 1));
        zb = za + atan_lut(4'(2 * g + 1));
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g+1] <= 1'b0;
      end else begin
        v_q[g+1] <= v_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      qd_q[g+1] <= qd_q[g];
      x_q[g+1] <= xb;
      y_q[g+1] <= yb;
      z_q[g+1] <= zb;
    end
  end

  // rounding, clamping and quadrant fold
  trig_t c0, s0;
  logic signed [32:0] xr, yr;
  always_comb begin
    xr = (33'(x_q[NumStg]) + 33'sd32768) >>> 16;
    yr = (33'(y_q[NumStg]) + 33'sd32768) >>> 16;
    c0 = (xr > 33'sd16384) ? 17'sd16384 : (xr < -33'sd16384) ? -17'sd16384 : trig_t'(xr);
    s0 = (yr > 33'sd16384) ? 17'sd16384 : (yr < -33'sd16384) ? -17'sd16384 : trig_t'(yr);
  end

  logic v_out_q;
  trig_t c_q, s_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_out_q <= 1'b0;
    end else begin
      v_out_q <= v_q[NumStg];
    end
  end
  always_ff @(posedge clk_i) begin
    case (qd_q[NumStg])
      2'd0: begin c_q <= c0;  s_q <= s0;  end
      2'd1: begin c_q <= -s0; s_q <= c0;  end
      2'd2: begin c_q <= -c0; s_q <= -s0; end
      default: begin c_q <= s0; s_q <= -c0; end
    endcase
  end

  assign valid_o = v_out_q;
  assign cos_o = c_q;
  assign sin_o = s_q;
endmodule

[rtl/core/hcm_elem.sv]
// pipelined evaluation of one matrix coefficient
module hcm_elem (
  input  logic                 clk_i,
  input  logic [3:0]           elem_i,
  input  logic [14:0]          sat_i,
  input  logic [14:0]          opa_i,
  input  hcm_pkg::trig_t       cos_i,
  input  hcm_pkg::trig_t       sin_i,
  output hcm_pkg::coef_t       coef_o
);
  import hcm_pkg::*;

  localparam logic signed [16:0] KPk = 17'sd21845;

  // stage a: weights from saturation
  logic signed [16:0] as_w, sa_w;
  logic signed [34:0] pc_d, ps_d;
  logic signed [34:0] pc_q, ps_q;
  trig_t c_a_q, s_a_q;
  logic [14:0] op_a_q;

  always_comb begin
    sa_w = 17'($signed({2'b00, sat_i}));
    as_w = 17'sd256 - sa_w;
    pc_d = 35'(elem_k(elem_i, 2'd0)) * 35'(as_w) + 35'(elem_k(elem_i, 2'd1)) * 35'(sa_w);
    ps_d = 35'(elem_k(elem_i, 2'd2)) * 35'(as_w) + 35'(elem_k(elem_i, 2'd3)) * 35'(sa_w);
  end

  always_ff @(posedge clk_i) begin
    pc_q <= pc_d;
    ps_q <= ps_d;
    c_a_q <= cos_i;
    s_a_q <= sin_i;
    op_a_q <= opa_i;
  end

  // stage b: trig products
  logic signed [51:0] mc_q, ms_q;
  logic [14:0] op_b_q;
  always_ff @(posedge clk_i) begin
    mc_q <= 52'(pc_q) * 52'(c_a_q);
    ms_q <= 52'(ps_q) * 52'(s_a_q);
    op_b_q <= op_a_q;
  end

  // stage c: sum with constant term (as + sa = 256)
  logic signed [52:0] t_q;
  logic [14:0] op_c_q;
  always_ff @(posedge clk_i) begin
    t_q <= 53'(mc_q) + 53'(ms_q) + 53'(KPk * 53'sd256 * 53'sd16384);
    op_c_q <= op_b_q;
  end

  // stage d: opacity product split into two partial products
  logic signed [68:0] m_lo_q, m_hi_q;
  logic [14:0] op_d_q;
  always_ff @(posedge clk_i) begin
    m_lo_q <= 69'($signed({1'b0, t_q[26:0]})) * 69'($signed({1'b0, op_c_q}));
    m_hi_q <= 69'($signed(t_q[52:27])) * 69'($signed({1'b0, op_c_q}));
    op_d_q <= op_c_q;
  end

  // stage e: combine, identity blend, round and saturate
  logic signed [68:0] m_w, r_w;
  always_comb begin
    m_w = (m_hi_q <<< 27) + m_lo_q;
    if (elem_diag(elem_i))
      m_w = m_w + ((69'sd16384 - 69'($signed({1'b0, op_d_q}))) <<< 38);
    r_w = (m_w + (69'sd1 <<< 37)) >>> 38;
  end

  coef_t coef_q;
  always_ff @(posedge clk_i) begin
    if (r_w > 69'(CoefMax)) coef_q <= CoefMax;
    else if (r_w < 69'(CoefMin)) coef_q <= CoefMin;
    else coef_q <= coef_t'(r_w);
  end

  assign coef_o = coef_q;
endmodule

[rtl/core/hsl_color_matrix_generator_unit.sv]
// top level of the hsl color matrix generator
// throughput: one transfer per cycle
// clamp stage, 10 cordic stages (quadrant split, 8 of two iterations each, quadrant fold),
// 5 coefficient stages, the last of them the output register
// busy_o is tied low: the pipeline never stalls since the receiver cannot hold off
// asynchronous active-low reset clears all valid bits; payload registers are not reset
module hsl_color_matrix_generator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] hue_i,
  input  logic [15:0]        saturation_i,
  input  logic signed [15:0] lightness_i,
  input  logic signed [15:0] opacity_i,
  output logic               valid_o,
  output logic signed [21:0] red_to_red_o,
  output logic signed [21:0] red_to_green_o,
  output logic signed [21:0] red_to_blue_o,
  output logic signed [21:0] green_to_red_o,
  output logic signed [21:0] green_to_green_o,
  output logic signed [21:0] green_to_blue_o,
  output logic signed [21:0] blue_to_red_o,
  output logic signed [21:0] blue_to_green_o,
  output logic signed [21:0] blue_to_blue_o,
  output logic signed [15:0] color_offset_o
);
  import hcm_pkg::*;
  `include "hsl_color_matrix_generator_unit_defines.svh"

  // delay through the cordic, and delay from cordic output to coefficient output
  localparam int unsigned CordLat = NumSteps / 2 + 2;
  localparam int unsigned ElemLat = 5;

  assign busy_o = 1'b0;

  // clamp stage
  logic        v_in_q;
  logic [14:0] hue_q, sat_q, opa_q;
  logic signed [15:0] lt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q <= 1'b0;
    end else begin
      v_in_q <= start_i;
    end
  end
  always_ff @(posedge clk_i) begin
    hue_q <= hue_i[15] ? 15'd0 : (17'(hue_i) > HueMax) ? 15'(HueMax) : hue_i[14:0];
    sat_q <= (saturation_i > SatMax) ? 15'(SatMax) : saturation_i[14:0];
    opa_q <= opacity_i[15] ? 15'd0 : (opacity_i > OneQ14) ? 15'(OneQ14) : opacity_i[14:0];
    lt_q  <= (lightness_i > OneQ14) ? OneQ14 : (lightness_i < -OneQ14) ? -OneQ14 : lightness_i;
  end

  // cosine and sine
  logic cord_v;
  trig_t cos_w, sin_w;
  hcm_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_in_q),
    .hue_i   (hue_q),
    .valid_o (cord_v),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  // saturation, opacity and lightness ride along with the cordic
  logic [14:0] sat_dl_q [CordLat];
  logic [14:0] opa_dl_q [CordLat];
  logic signed [15:0] lt_dl_q [CordLat];
  always_ff @(posedge clk_i) begin
    sat_dl_q[0] <= sat_q;
    opa_dl_q[0] <= opa_q;
    lt_dl_q[0] <= lt_q;
    for (int i = 1; i < CordLat; i++) begin
      sat_dl_q[i] <= sat_dl_q[i-1];
      opa_dl_q[i] <= opa_dl_q[i-1];
      lt_dl_q[i] <= lt_dl_q[i-1];
    end
  end

  // nine coefficient lanes
  coef_t coef_w [NumElem];
  for (genvar e = 0; e < NumElem; e++) begin : g_elem
    hcm_elem u_elem (
      .clk_i  (clk_i),
      .elem_i (4'(e)),
      .sat_i  (sat_dl_q[CordLat-1]),
      .opa_i  (opa_dl_q[CordLat-1]),
      .cos_i  (cos_w),
      .sin_i  (sin_w),
      .coef_o (coef_w[e])
    );
  end

  // offset path: lightness times opacity, rounded, delayed to match
  logic signed [15:0] off_dl_q [ElemLat];
  logic               v_dl_q [ElemLat];
  always_ff @(posedge clk_i) begin
    off_dl_q[0] <= 16'((32'(lt_dl_q[CordLat-1]) * 32'($signed({1'b0, opa_dl_q[CordLat-1]}))
                        + 32'sd8192) >>> 14);
    for (int i = 1; i < ElemLat; i++) off_dl_q[i] <= off_dl_q[i-1];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ElemLat; i++) v_dl_q[i] <= 1'b0;
    end else begin
      v_dl_q[0] <= cord_v;
      for (int i = 1; i < ElemLat; i++) v_dl_q[i] <= v_dl_q[i-1];
    end
  end

  assign valid_o = v_dl_q[ElemLat-1];
  assign red_to_red_o     = coef_w[0];
  assign red_to_green_o   = coef_w[1];
  assign red_to_blue_o    = coef_w[2];
  assign green_to_red_o   = coef_w[3];
  assign green_to_green_o = coef_w[4];
  assign green_to_blue_o  = coef_w[5];
  assign blue_to_red_o    = coef_w[6];
  assign blue_to_green_o  = coef_w[7];
  assign blue_to_blue_o   = coef_w[8];
  assign color_offset_o   = off_dl_q[ElemLat-1];

  `HCM_ASSERT(a_never_busy, clk_i, rst_ni, !busy_o, "busy raised")
  `HCM_ASSERT_IMPL(a_offset_range, clk_i, rst_ni, valid_o,
    (color_offset_o <= 16'sd16384) && (color_offset_o >= -16'sd16384), "offset out of range")
  `HCM_ASSERT_IMPL(a_start_reaches_out, clk_i, rst_ni, start_i, ##16 valid_o,
    "lost transfer")
endmodule
